>>> hw/rtl/spcsr_pkg.sv
// ----------------------------------------------------------------------------
// Sparse CSR matrix lookup package
// Sizes, command codes, item and result records, sequencer states.
// ----------------------------------------------------------------------------
package spcsr_pkg;

	localparam int MAX_DIM     = 64;
	localparam int MAX_ENTRIES = 1024;

	localparam int CMD_W    = 3;
	localparam int EIDX_W   = 10;
	localparam int ROW_W    = 7;
	localparam int COL_W    = 6;
	localparam int VAL_W    = 32;
	localparam int PTR_W    = 11;
	localparam int POS_W    = 6;

	localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
	localparam int IDX_W    = ENTRY_AW + 1;
	localparam int RS_DEPTH = MAX_DIM + 1;
	localparam int RS_AW    = $clog2(RS_DEPTH);
	localparam int DIM_AW   = $clog2(MAX_DIM);
	localparam int ENT_W    = VAL_W + COL_W;

	localparam int IN_BITS     = EIDX_W + ROW_W + COL_W + VAL_W + PTR_W;
	localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = VAL_W + POS_W;
	localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [VAL_W-1:0] ERR_WORD  = 32'hC000_0000;
	localparam logic [VAL_W-1:0] ZERO_WORD = '0;

	localparam logic [CMD_W-1:0] CMD_LOAD_ENTRY = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_PTR   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_GET_ELEM   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_GET_ROW    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET_COL    = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [EIDX_W-1:0] entry_index;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  column;
		logic [VAL_W-1:0]  value_bits;
		logic [PTR_W-1:0]  pointer;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] value_out;
		logic [POS_W-1:0] position;
		logic             status;
		logic             last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_RD_LO,
		ST_RD_HI,
		ST_RANGE,
		ST_SCAN,
		ST_DONE,
		ST_DUMP_RD,
		ST_DUMP_WR
	} state_t;

endpackage

>>> hw/rtl/spcsr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spcsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/spcsr_engine.sv
// ----------------------------------------------------------------------------
// Sparse CSR lookup engine
// Entry, row start and dense row stores, with the sequencer that scans a
// row's entry range one entry per cycle through a shared column compare.
// ----------------------------------------------------------------------------
module spcsr_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [spcsr_pkg::ROW_W-1:0] dim,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  spcsr_pkg::item_t          in_item,
	input  logic                      out_free,
	output logic                      res_push,
	output spcsr_pkg::res_t           res
);

	spcsr_pkg::state_t state_q, state_d;

	logic [spcsr_pkg::CMD_W-1:0]  cmd_q, cmd_d;
	logic [spcsr_pkg::ROW_W-1:0]  cur_q, cur_d;
	logic [spcsr_pkg::ROW_W-1:0]  dump_q, dump_d;
	logic [spcsr_pkg::COL_W-1:0]  col_q, col_d;
	logic [spcsr_pkg::PTR_W-1:0]  lo_q, lo_d;
	logic [spcsr_pkg::IDX_W-1:0]  idx_q, idx_d;
	logic [spcsr_pkg::IDX_W-1:0]  hi_q, hi_d;
	logic                         pend_q, pend_d;
	logic [spcsr_pkg::VAL_W-1:0]  acc_q, acc_d;
	logic [spcsr_pkg::MAX_DIM-1:0] valid_q, valid_d;

	logic                         accept;
	logic [31:0]                  eidx_w;
	logic                         ent_we;
	logic [spcsr_pkg::ENT_W-1:0]  ent_rdata;
	logic [spcsr_pkg::VAL_W-1:0]  ent_val;
	logic [spcsr_pkg::COL_W-1:0]  ent_col;
	logic                         rs_we;
	logic [spcsr_pkg::RS_AW-1:0]  rs_raddr;
	logic [spcsr_pkg::PTR_W-1:0]  rs_rdata;
	logic [spcsr_pkg::ROW_W-1:0]  cur_inc;
	logic [spcsr_pkg::ROW_W-1:0]  dump_inc;
	logic                         dn_we;
	logic [spcsr_pkg::VAL_W-1:0]  dn_rdata;
	logic [31:0]                  b32, hi32, lo32;
	logic                         col_in_dim;
	logic                         col_match;
	logic                         scan_more;

	assign accept   = in_valid && in_ready;
	assign eidx_w   = 32'(in_item.entry_index);
	assign ent_we   = accept && (in_item.cmd == spcsr_pkg::CMD_LOAD_ENTRY) &&
		(eidx_w < 32'(spcsr_pkg::MAX_ENTRIES));
	assign rs_we    = accept && (in_item.cmd == spcsr_pkg::CMD_LOAD_PTR) &&
		(32'(in_item.row) <= 32'(spcsr_pkg::MAX_DIM));
	assign cur_inc  = cur_q + 1'b1;
	assign dump_inc = dump_q + 1'b1;
	assign rs_raddr = (state_q == spcsr_pkg::ST_RD_HI) ? cur_inc[spcsr_pkg::RS_AW-1:0] :
		cur_q[spcsr_pkg::RS_AW-1:0];

	assign ent_val    = ent_rdata[spcsr_pkg::ENT_W-1:spcsr_pkg::COL_W];
	assign ent_col    = ent_rdata[spcsr_pkg::COL_W-1:0];
	assign col_in_dim = {1'b0, ent_col} < dim;
	assign col_match  = (cmd_q == spcsr_pkg::CMD_GET_ROW) ? col_in_dim : (ent_col == col_q);
	assign scan_more  = idx_q < hi_q;
	assign dn_we      = (state_q == spcsr_pkg::ST_SCAN) && pend_q &&
		(cmd_q == spcsr_pkg::CMD_GET_ROW) && col_match;

	assign b32  = 32'(rs_rdata);
	assign hi32 = (b32 > 32'(spcsr_pkg::MAX_ENTRIES)) ? 32'(spcsr_pkg::MAX_ENTRIES) : b32;
	assign lo32 = (32'(lo_q) > hi32) ? hi32 : 32'(lo_q);

	spcsr_ram #(
		.WIDTH(spcsr_pkg::ENT_W),
		.DEPTH(spcsr_pkg::MAX_ENTRIES)
	) u_entries (
		.clk  (clk),
		.we   (ent_we),
		.waddr(eidx_w[spcsr_pkg::ENTRY_AW-1:0]),
		.wdata({in_item.value_bits, in_item.column}),
		.raddr(idx_q[spcsr_pkg::ENTRY_AW-1:0]),
		.rdata(ent_rdata)
	);

	spcsr_ram #(
		.WIDTH(spcsr_pkg::PTR_W),
		.DEPTH(spcsr_pkg::RS_DEPTH)
	) u_row_starts (
		.clk  (clk),
		.we   (rs_we),
		.waddr(in_item.row[spcsr_pkg::RS_AW-1:0]),
		.wdata(in_item.pointer),
		.raddr(rs_raddr),
		.rdata(rs_rdata)
	);

	spcsr_ram #(
		.WIDTH(spcsr_pkg::VAL_W),
		.DEPTH(spcsr_pkg::MAX_DIM)
	) u_dense (
		.clk  (clk),
		.we   (dn_we),
		.waddr(ent_col[spcsr_pkg::DIM_AW-1:0]),
		.wdata(ent_val),
		.raddr(dump_q[spcsr_pkg::DIM_AW-1:0]),
		.rdata(dn_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spcsr_pkg::ST_IDLE;
			pend_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		cur_q  <= cur_d;
		dump_q <= dump_d;
		col_q  <= col_d;
		lo_q   <= lo_d;
		idx_q  <= idx_d;
		hi_q   <= hi_d;
		acc_q  <= acc_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		cur_d    = cur_q;
		dump_d   = dump_q;
		col_d    = col_q;
		lo_d     = lo_q;
		idx_d    = idx_q;
		hi_d     = hi_q;
		pend_d   = pend_q;
		acc_d    = acc_q;
		valid_d  = valid_q;
		in_ready = 1'b0;
		res_push = 1'b0;
		res      = '0;

		unique case (state_q)
			spcsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_d = in_item.cmd;
					col_d = in_item.column;
					unique case (in_item.cmd) inside
						spcsr_pkg::CMD_GET_ELEM: begin
							cur_d = in_item.row;
							if ((in_item.row >= dim) || ({1'b0, in_item.column} >= dim)) begin
								state_d = spcsr_pkg::ST_ERR;
							end else begin
								state_d = spcsr_pkg::ST_RD_LO;
							end
						end
						spcsr_pkg::CMD_GET_ROW: begin
							cur_d   = in_item.row;
							valid_d = '0;
							if (in_item.row >= dim) begin
								state_d = spcsr_pkg::ST_ERR;
							end else begin
								state_d = spcsr_pkg::ST_RD_LO;
							end
						end
						spcsr_pkg::CMD_GET_COL: begin
							cur_d = '0;
							if ({1'b0, in_item.column} >= dim) begin
								state_d = spcsr_pkg::ST_ERR;
							end else begin
								state_d = spcsr_pkg::ST_RD_LO;
							end
						end
						default: begin
							state_d = spcsr_pkg::ST_IDLE;
						end
					endcase
				end
			end
			spcsr_pkg::ST_ERR: begin
				if (out_free) begin
					res_push      = 1'b1;
					res.value_out = (cmd_q == spcsr_pkg::CMD_GET_ELEM) ? spcsr_pkg::ERR_WORD :
						spcsr_pkg::ZERO_WORD;
					res.status    = 1'b1;
					res.last      = 1'b1;
					state_d       = spcsr_pkg::ST_IDLE;
				end
			end
			spcsr_pkg::ST_RD_LO: begin
				state_d = spcsr_pkg::ST_RD_HI;
			end
			spcsr_pkg::ST_RD_HI: begin
				lo_d    = rs_rdata;
				state_d = spcsr_pkg::ST_RANGE;
			end
			spcsr_pkg::ST_RANGE: begin
				idx_d   = lo32[spcsr_pkg::IDX_W-1:0];
				hi_d    = hi32[spcsr_pkg::IDX_W-1:0];
				acc_d   = spcsr_pkg::ZERO_WORD;
				pend_d  = 1'b0;
				state_d = spcsr_pkg::ST_SCAN;
			end
			spcsr_pkg::ST_SCAN: begin
				if (pend_q && col_match) begin
					acc_d = ent_val;
					if (cmd_q == spcsr_pkg::CMD_GET_ROW) begin
						valid_d[ent_col[spcsr_pkg::DIM_AW-1:0]] = 1'b1;
					end
				end
				if (scan_more) begin
					idx_d  = idx_q + 1'b1;
					pend_d = 1'b1;
				end else begin
					pend_d = 1'b0;
				end
				if (!pend_q && !scan_more) begin
					if (cmd_q == spcsr_pkg::CMD_GET_ROW) begin
						dump_d  = '0;
						state_d = spcsr_pkg::ST_DUMP_RD;
					end else begin
						state_d = spcsr_pkg::ST_DONE;
					end
				end
			end
			spcsr_pkg::ST_DONE: begin
				if (out_free) begin
					res_push      = 1'b1;
					res.value_out = acc_q;
					if (cmd_q == spcsr_pkg::CMD_GET_ELEM) begin
						res.last = 1'b1;
						state_d  = spcsr_pkg::ST_IDLE;
					end else begin
						res.position = cur_q[spcsr_pkg::POS_W-1:0];
						res.last     = (cur_inc == dim);
						cur_d        = cur_inc;
						state_d      = (cur_inc == dim) ? spcsr_pkg::ST_IDLE :
							spcsr_pkg::ST_RD_LO;
					end
				end
			end
			spcsr_pkg::ST_DUMP_RD: begin
				state_d = spcsr_pkg::ST_DUMP_WR;
			end
			spcsr_pkg::ST_DUMP_WR: begin
				if (out_free) begin
					res_push      = 1'b1;
					res.value_out = valid_q[dump_q[spcsr_pkg::DIM_AW-1:0]] ? dn_rdata :
						spcsr_pkg::ZERO_WORD;
					res.position  = dump_q[spcsr_pkg::POS_W-1:0];
					res.last      = (dump_inc == dim);
					dump_d        = dump_inc;
					state_d       = (dump_inc == dim) ? spcsr_pkg::ST_IDLE :
						spcsr_pkg::ST_DUMP_RD;
				end
			end
			default: begin
				state_d = spcsr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/sparse_csr_matrix_lookup.sv
// ----------------------------------------------------------------------------
// Sparse CSR matrix lookup
// Square sparse matrix in compressed sparse row form with element, row and
// column queries on a word stream.
// ----------------------------------------------------------------------------
// Load words (entry or row start) give no result. An element query reads the
// row's two row starts, scans the entries in the row's range and gives one
// result; a row query scans the row's range into the dense row buffer, then
// reads it out as one word per column for the dimension in use; a column
// query runs the element steps for every row in use, one word per row. The
// scan goes through the single entry memory read port, one entry per cycle,
// and each result waits until the output register is free. The block takes no
// new word while a query runs; a result word waits in the output register
// without stopping the next query from being accepted once the last one is
// queued. An out-of-range query gives one error word.
module sparse_csr_matrix_lookup (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [spcsr_pkg::ROW_W-1:0]       cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// entry_index, row, column, value_bits, pointer, zero pad
	input  logic [spcsr_pkg::S_TDATA_W-1:0]   s_tdata,
	// command
	input  logic [spcsr_pkg::CMD_W-1:0]       s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// value_out, position, zero pad
	output logic [spcsr_pkg::M_TDATA_W-1:0]   m_tdata,
	// status
	output logic [0:0]                        m_tuser,
	output logic                              m_tlast
);

	logic [spcsr_pkg::ROW_W-1:0] dim_q;
	logic [spcsr_pkg::ROW_W-1:0] dim_n;
	spcsr_pkg::item_t            item;
	spcsr_pkg::res_t             res;
	spcsr_pkg::res_t             out_q;
	logic                        res_push;
	logic                        out_free;
	logic                        m_tvalid_q;

	assign dim_n = (32'(dim_q) > 32'(spcsr_pkg::MAX_DIM)) ?
		spcsr_pkg::ROW_W'(spcsr_pkg::MAX_DIM) : dim_q;

	assign item.cmd         = s_tuser;
	assign item.entry_index = s_tdata[9:0];
	assign item.row         = s_tdata[16:10];
	assign item.column      = s_tdata[22:17];
	assign item.value_bits  = s_tdata[54:23];
	assign item.pointer     = s_tdata[65:55];

	assign out_free = !m_tvalid_q || m_tready;

	spcsr_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.dim     (dim_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item (item),
		.out_free(out_free),
		.res_push(res_push),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				dim_q <= cfg_wdata;
			end
			if (res_push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(spcsr_pkg::M_TDATA_W - spcsr_pkg::OUT_BITS){1'b0}},
		out_q.position, out_q.value_out};
	assign m_tuser  = out_q.status;
	assign m_tlast  = out_q.last;

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!m_tvalid || m_tready))
		else $error("result pushed over a pending word");

	a_busy_mid_query: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input taken before the query finished");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata[37:32] == '0)))
		else $error("error word not a lone final word");

	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled word changed");

endmodule
